@@ design/etpg_pkg.sv @@
// shared types, constants and register codes for the enveloped tone pwm generator
package etpg_pkg;

	localparam int SINE_ADDR_BITS_DEF      = 10;
	localparam int DECAY_TABLE_ENTRIES_DEF = 256;
	localparam int ENVELOPE_FRAC_BITS_DEF  = 16;
	localparam int QUEUE_DEPTH             = 4;
	localparam int APB_ADDR_W              = 5;

	localparam logic [63:0] Q31_ONE     = 64'h0000_0000_8000_0000;
	localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;

	localparam logic REQ_SERVICE = 1'b0;
	localparam logic REQ_TRIGGER = 1'b1;

	typedef enum logic [2:0] {
		REG_SAMPLE_PERIOD = 3'd0,
		REG_PHASE_STEP    = 3'd1,
		REG_BEEP_LENGTH   = 3'd2,
		REG_ATTACK        = 3'd3,
		REG_DECAY         = 3'd4,
		REG_DUTY_RANGE    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic        req_type;
		logic [31:0] now_ms;
		logic [31:0] now_us;
	} cmd_t;

	typedef struct packed {
		logic [15:0] duty;
		logic        sounding;
	} res_t;

	typedef struct packed {
		logic        trigger;
		logic [31:0] now_ms;
	} job_t;

	typedef struct packed {
		logic        full;
		logic        not_empty;
	} queue_stat_t;

	typedef struct packed {
		logic [15:0] sample_period_us;
		logic [31:0] phase_step;
		logic [15:0] beep_length_ms;
		logic [15:0] attack_ms;
		logic [15:0] decay_ms;
		logic [15:0] duty_range;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		sample_period_us: 16'd125,
		phase_step:       32'h4000_0000,
		beep_length_ms:   16'd120,
		attack_ms:        16'd5,
		decay_ms:         16'd40,
		duty_range:       16'd1023
	};

endpackage

@@ design/etpg_front.sv @@
// front end: takes items, gates service ticks on the sample period, feeds the queue
module etpg_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_stall,
	input  etpg_pkg::cmd_t         cmd,
	input  etpg_pkg::cfg_t         cfg,
	input  etpg_pkg::queue_stat_t  q_stat,
	output logic                   push,
	output etpg_pkg::job_t         job
);

	logic        accept;
	logic        is_trig;
	logic        due;
	logic [31:0] gap;
	logic [31:0] last_sample_us_q;

	assign cmd_stall = q_stat.full;
	assign accept    = cmd_valid && !cmd_stall;
	assign is_trig   = (cmd.req_type == etpg_pkg::REQ_TRIGGER);
	assign gap       = cmd.now_us - last_sample_us_q;
	assign due       = (gap >= {16'd0, cfg.sample_period_us});
	assign push      = accept && (is_trig || due);
	assign job       = '{trigger: is_trig, now_ms: cmd.now_ms};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sample_us_q <= '0;
		end else if (accept && !is_trig && due) begin
			last_sample_us_q <= cmd.now_us;
		end
	end

endmodule

@@ design/etpg_queue.sv @@
// short item queue between the front end and the tone engine
module etpg_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  etpg_pkg::job_t         job_in,
	input  logic                   pop,
	output etpg_pkg::job_t         head,
	output etpg_pkg::queue_stat_t  q_stat
);

	localparam int DEPTH = etpg_pkg::QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	etpg_pkg::job_t slots_q [DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [CW-1:0]  count_q;

	assign head             = slots_q[rd_q];
	assign q_stat.full      = (count_q == CW'(DEPTH));
	assign q_stat.not_empty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

@@ design/etpg_back.sv @@
// tone engine: beep state, envelope divider, sine and decay roms, duty scaling
module etpg_back #(
	parameter int SINE_ADDR_BITS      = etpg_pkg::SINE_ADDR_BITS_DEF,
	parameter int DECAY_TABLE_ENTRIES = etpg_pkg::DECAY_TABLE_ENTRIES_DEF,
	parameter int ENVELOPE_FRAC_BITS  = etpg_pkg::ENVELOPE_FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  etpg_pkg::cfg_t         cfg,
	input  etpg_pkg::job_t         head,
	input  etpg_pkg::queue_stat_t  q_stat,
	output logic                   pop,
	output logic                   res_valid,
	input  logic                   res_stall,
	output etpg_pkg::res_t         res
);

	localparam int FB     = ENVELOPE_FRAC_BITS;
	localparam int ENV_W  = FB + 1;
	localparam int QBITS  = SINE_ADDR_BITS - 2;
	localparam int QSIZE  = 1 << QBITS;
	localparam int DIB    = $clog2(DECAY_TABLE_ENTRIES);
	localparam int QB     = DIB + 1;
	localparam int EN_W   = 16 + $clog2(DECAY_TABLE_ENTRIES + 1);
	localparam int RW     = 18;
	localparam int QW     = (FB > QB) ? FB : QB;
	localparam int CNT_W  = $clog2(QW + 1);
	localparam int NUM_W  = 16 + FB;
	localparam int MAC_W  = FB + 18;
	localparam int PROD_W = NUM_W + 16;

	localparam logic [63:0]      Z_DIV    = 64'(10 * DECAY_TABLE_ENTRIES);
	localparam logic [QBITS:0]   QSIZE_V  = {1'b1, {QBITS{1'b0}}};
	localparam logic [DIB-1:0]   IDX_LAST = DIB'(DECAY_TABLE_ENTRIES - 1);
	localparam logic [QW-1:0]    N_V      = QW'(DECAY_TABLE_ENTRIES);
	localparam logic signed [MAC_W-1:0] MAC_OFS = $signed(MAC_W'(1) << (15 + FB));

	typedef logic [14:0]      sine_rom_t  [QSIZE + 1];
	typedef logic [ENV_W-1:0] decay_rom_t [DECAY_TABLE_ENTRIES];

	function automatic sine_rom_t build_sine();
		sine_rom_t   rom;
		logic [63:0] th;
		logic [63:0] th2;
		logic [63:0] h;
		logic [63:0] s;
		logic [63:0] q;
		for (int r = 0; r <= QSIZE; r++) begin
			th  = (etpg_pkg::HALF_PI_Q31 * 64'(r)) >> QBITS;
			th2 = (th * th) >> 31;
			h   = etpg_pkg::Q31_ONE;
			h   = etpg_pkg::Q31_ONE - ((th2 * h) >> 31) / 64'd110;
			h   = etpg_pkg::Q31_ONE - ((th2 * h) >> 31) / 64'd72;
			h   = etpg_pkg::Q31_ONE - ((th2 * h) >> 31) / 64'd42;
			h   = etpg_pkg::Q31_ONE - ((th2 * h) >> 31) / 64'd20;
			h   = etpg_pkg::Q31_ONE - ((th2 * h) >> 31) / 64'd6;
			s   = (th * h) >> 31;
			q   = (s + 64'd32768) >> 16;
			if (q > 64'd32767) begin
				q = 64'd32767;
			end
			rom[r] = q[14:0];
		end
		return rom;
	endfunction

	function automatic decay_rom_t build_decay();
		decay_rom_t  rom;
		logic [63:0] z;
		logic [63:0] w;
		logic [63:0] w2;
		logic [63:0] w3;
		logic [63:0] w4;
		logic [63:0] t;
		for (int i = 0; i < DECAY_TABLE_ENTRIES; i++) begin
			z  = ((64'd112 << 31) * 64'(i)) / Z_DIV;
			w  = z >> 6;
			w2 = (w * w) >> 31;
			w3 = (w2 * w) >> 31;
			w4 = (w3 * w) >> 31;
			t  = etpg_pkg::Q31_ONE + w2 / 64'd2 + w4 / 64'd24 - w - w3 / 64'd6;
			for (int k = 0; k < 6; k++) begin
				t = (t * t) >> 31;
			end
			t = (t + (64'd1 << (30 - FB))) >> (31 - FB);
			rom[i] = t[ENV_W-1:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t  SINE_ROM  = build_sine();
	localparam decay_rom_t DECAY_ROM = build_decay();

	typedef enum logic [7:0] {
		B_IDLE  = 8'b0000_0001,
		B_EPROD = 8'b0000_0010,
		B_DCHK  = 8'b0000_0100,
		B_DIV   = 8'b0000_1000,
		B_DROM  = 8'b0001_0000,
		B_MAC   = 8'b0010_0000,
		B_SCALE = 8'b0100_0000,
		B_OUT   = 8'b1000_0000
	} bstate_t;

	bstate_t state_q;
	bstate_t state_d;

	logic        active_q;
	logic [31:0] start_q;
	logic [31:0] phase_q;
	logic        res_valid_q;
	etpg_pkg::res_t res_q;
	etpg_pkg::res_t res_d;

	logic [15:0]        e_q;
	logic [EN_W-1:0]    en_q;
	logic [RW-1:0]      rem_q;
	logic [RW-1:0]      div_q;
	logic [QW-1:0]      low_q;
	logic [QW-1:0]      quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               attack_q;
	logic [ENV_W-1:0]   env_q;
	logic               sneg_q;
	logic [14:0]        sine_mag_q;
	logic [ENV_W-1:0]   dec_q;
	logic [NUM_W-1:0]   num_q;
	logic [PROD_W-1:0]  dprod_q;

	logic [31:0]               elapsed;
	logic                      expired;
	logic                      silent;
	logic                      in_attack;
	logic                      out_free;
	logic [SINE_ADDR_BITS-1:0] saddr;
	logic [1:0]                quad;
	logic [QBITS:0]            r0;
	logic [QBITS:0]            sine_idx;
	logic [15:0]               dec_nz;
	logic [RW-1:0]             div4;
	logic [RW-1:0]             hi_ext;
	logic                      ovf;
	logic [RW:0]               trial;
	logic [RW:0]               diff;
	logic                      ge;
	logic [RW-1:0]             rem_nx;
	logic [QW-1:0]             quo_nx;
	logic                      div_last;
	logic                      dec_rd;
	logic [DIB-1:0]            dec_idx;
	logic                      sine_rd;
	logic                      go_trig;
	logic                      go_silent;
	logic                      go_sound;
	logic                      load_res;
	logic signed [15:0]        sine_val;
	logic signed [MAC_W-1:0]   mac;
	logic [15:0]               dval;
	logic [15:0]               duty_out;

	assign elapsed   = head.now_ms - start_q;
	assign expired   = (elapsed >= {16'd0, cfg.beep_length_ms});
	assign silent    = !active_q || expired;
	assign in_attack = (elapsed[15:0] < cfg.attack_ms);
	assign out_free  = !res_valid_q || !res_stall;

	assign saddr    = phase_q[31:32-SINE_ADDR_BITS];
	assign quad     = saddr[SINE_ADDR_BITS-1:SINE_ADDR_BITS-2];
	assign r0       = {1'b0, saddr[QBITS-1:0]};
	assign sine_idx = quad[0] ? (QSIZE_V - r0) : r0;

	assign dec_nz = (cfg.decay_ms == 16'd0) ? 16'd1 : cfg.decay_ms;
	assign div4   = {dec_nz, 2'b00};
	assign hi_ext = RW'(en_q[EN_W-1:QB]);
	assign ovf    = (hi_ext >= div4);

	// one quotient bit per cycle
	assign trial    = {rem_q, low_q[QW-1]};
	assign diff     = trial - {1'b0, div_q};
	assign ge       = (trial >= {1'b0, div_q});
	assign rem_nx   = ge ? diff[RW-1:0] : trial[RW-1:0];
	assign quo_nx   = {quo_q[QW-2:0], ge};
	assign div_last = (cnt_q == CNT_W'(1));

	always_comb begin
		dec_rd  = 1'b0;
		dec_idx = IDX_LAST;
		if (state_q == B_DCHK && ovf) begin
			dec_rd = 1'b1;
		end else if (state_q == B_DIV && div_last && !attack_q) begin
			dec_rd = 1'b1;
			if (quo_nx < N_V) begin
				dec_idx = quo_nx[DIB-1:0];
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		sine_rd   = 1'b0;
		go_trig   = 1'b0;
		go_silent = 1'b0;
		go_sound  = 1'b0;
		load_res  = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (q_stat.not_empty) begin
					if (head.trigger) begin
						pop     = 1'b1;
						go_trig = 1'b1;
					end else if (silent) begin
						if (out_free) begin
							pop       = 1'b1;
							go_silent = 1'b1;
							load_res  = 1'b1;
						end
					end else begin
						pop      = 1'b1;
						go_sound = 1'b1;
						sine_rd  = 1'b1;
						state_d  = in_attack ? B_DIV : B_EPROD;
					end
				end
			end
			B_EPROD: state_d = B_DCHK;
			B_DCHK:  state_d = ovf ? B_DROM : B_DIV;
			B_DIV: begin
				if (div_last) begin
					state_d = attack_q ? B_MAC : B_DROM;
				end
			end
			B_DROM:  state_d = B_MAC;
			B_MAC:   state_d = B_SCALE;
			B_SCALE: state_d = B_OUT;
			B_OUT: begin
				if (out_free) begin
					load_res = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	assign sine_val = sneg_q ? -$signed({1'b0, sine_mag_q}) : $signed({1'b0, sine_mag_q});
	assign mac      = sine_val * $signed({1'b0, env_q}) + MAC_OFS;
	assign dval     = dprod_q[PROD_W-1:NUM_W];
	assign duty_out = (dval > cfg.duty_range) ? cfg.duty_range : dval;
	assign res_d    = go_silent ? etpg_pkg::res_t'{duty: 16'd0, sounding: 1'b0}
	                            : etpg_pkg::res_t'{duty: duty_out, sounding: 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			active_q    <= 1'b0;
			start_q     <= '0;
			phase_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (go_trig) begin
				active_q <= 1'b1;
				start_q  <= head.now_ms;
				phase_q  <= '0;
			end else if (go_silent) begin
				active_q <= 1'b0;
			end else if (go_sound) begin
				phase_q <= phase_q + cfg.phase_step;
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sine_rd) begin
			sine_mag_q <= SINE_ROM[sine_idx];
			sneg_q     <= quad[1];
		end
		if (dec_rd) begin
			dec_q <= DECAY_ROM[dec_idx];
		end
		if (load_res) begin
			res_q <= res_d;
		end
		case (state_q)
			B_IDLE: begin
				if (go_sound) begin
					attack_q <= in_attack;
					e_q      <= elapsed[15:0] - cfg.attack_ms;
					rem_q    <= RW'(elapsed[15:0]);
					div_q    <= RW'(cfg.attack_ms);
					low_q    <= '0;
					quo_q    <= '0;
					cnt_q    <= CNT_W'(FB);
				end
			end
			B_EPROD: begin
				en_q <= EN_W'(e_q) * EN_W'(DECAY_TABLE_ENTRIES);
			end
			B_DCHK: begin
				rem_q <= hi_ext;
				div_q <= div4;
				low_q <= (QW'(en_q[QB-1:0])) << (QW - QB);
				quo_q <= '0;
				cnt_q <= CNT_W'(QB);
			end
			B_DIV: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				low_q <= low_q << 1;
				cnt_q <= cnt_q - CNT_W'(1);
				if (div_last && attack_q) begin
					env_q <= ENV_W'(quo_nx[FB-1:0]);
				end
			end
			B_DROM: begin
				env_q <= dec_q;
			end
			B_MAC: begin
				num_q <= mac[NUM_W-1:0];
			end
			B_SCALE: begin
				dprod_q <= PROD_W'(num_q) * PROD_W'(cfg.duty_range);
			end
			default: ;
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

@@ design/enveloped_tone_pwm_generator.sv @@
// top level: register port, front end, item queue and tone engine
// path: trigger and silent ticks go via the queue to idle; a sounding tick divides in attack,
//   or runs product, check, divide (not past the table), rom in decay; then mac, scale, out
// throughput: items enter one a cycle while the 4-deep queue has room; the tone engine
//   takes one item at a time, sounding ticks paced by the bit-serial envelope divider and res_stall
// reset: registers to defaults, beep idle, phase and sample time zero; no clearing pass
module enveloped_tone_pwm_generator #(
	parameter int SINE_ADDR_BITS      = etpg_pkg::SINE_ADDR_BITS_DEF,
	parameter int DECAY_TABLE_ENTRIES = etpg_pkg::DECAY_TABLE_ENTRIES_DEF,
	parameter int ENVELOPE_FRAC_BITS  = etpg_pkg::ENVELOPE_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	output logic                              cmd_stall,
	input  etpg_pkg::cmd_t                    cmd,
	output logic                              res_valid,
	input  logic                              res_stall,
	output etpg_pkg::res_t                    res,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [etpg_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	etpg_pkg::cfg_t        cfg_q;
	etpg_pkg::reg_idx_t    reg_idx;
	etpg_pkg::queue_stat_t q_stat;
	etpg_pkg::job_t        job;
	etpg_pkg::job_t        head;
	logic                  wr_en;
	logic                  push;
	logic                  pop;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = etpg_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= etpg_pkg::CFG_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				etpg_pkg::REG_SAMPLE_PERIOD: cfg_q.sample_period_us <= pwdata[15:0];
				etpg_pkg::REG_PHASE_STEP:    cfg_q.phase_step       <= pwdata;
				etpg_pkg::REG_BEEP_LENGTH:   cfg_q.beep_length_ms   <= pwdata[15:0];
				etpg_pkg::REG_ATTACK:        cfg_q.attack_ms        <= pwdata[15:0];
				etpg_pkg::REG_DECAY:         cfg_q.decay_ms         <= pwdata[15:0];
				etpg_pkg::REG_DUTY_RANGE:    cfg_q.duty_range       <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			etpg_pkg::REG_SAMPLE_PERIOD: prdata = {16'd0, cfg_q.sample_period_us};
			etpg_pkg::REG_PHASE_STEP:    prdata = cfg_q.phase_step;
			etpg_pkg::REG_BEEP_LENGTH:   prdata = {16'd0, cfg_q.beep_length_ms};
			etpg_pkg::REG_ATTACK:        prdata = {16'd0, cfg_q.attack_ms};
			etpg_pkg::REG_DECAY:         prdata = {16'd0, cfg_q.decay_ms};
			etpg_pkg::REG_DUTY_RANGE:    prdata = {16'd0, cfg_q.duty_range};
			default:                     prdata = 32'd0;
		endcase
	end

	etpg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.cfg       (cfg_q),
		.q_stat    (q_stat),
		.push      (push),
		.job       (job)
	);

	etpg_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.job_in (job),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	etpg_back #(
		.SINE_ADDR_BITS      (SINE_ADDR_BITS),
		.DECAY_TABLE_ENTRIES (DECAY_TABLE_ENTRIES),
		.ENVELOPE_FRAC_BITS  (ENVELOPE_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_stat.not_empty)
		else $error("queue popped while empty");

	a_push_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cmd_valid && !cmd_stall))
		else $error("queue written without an accepted item");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.full && !pop) |=> !q_stat.not_empty || q_stat.full)
		else $error("queue lost its full state without a pop");

	a_silent_duty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.sounding) |-> (res.duty == 16'd0))
		else $error("silent item carries a nonzero duty");

endmodule
